// ----- design/ppt_pkg.sv -----
// Shared constants, beat types and command type for the per-scan point transform.
package ppt_pkg;

    // Sizing of the pose table and the arithmetic.
    localparam int MAX_SCANS     = 256;
    localparam int ROT_FRAC_BITS = 30;
    localparam int TAG_FRAC_BITS = 8;
    localparam int TAG_SCAN_STEP = 100;

    // Fixed field widths of the beats.
    localparam int DATA_W     = 32;
    localparam int TAG_W      = 23;
    localparam int ELEM_W     = 4;
    localparam int POSE_IDX_W = 8;

    // Pose layout: rotation row-major first, then the translation vector.
    localparam int POSE_DIM   = 3;
    localparam int TRANS_BASE = POSE_DIM * POSE_DIM;
    localparam int POSE_WORDS = TRANS_BASE + POSE_DIM;

    localparam int SCAN_W = $clog2(MAX_SCANS);

    // Scan number = floor(integer part of tag / 100), done as a multiply by a
    // truncated reciprocal followed by a single correction step.
    localparam int     TAG_INT_W = TAG_W - TAG_FRAC_BITS;
    localparam int     RECIP_SH  = TAG_INT_W + 7;
    localparam longint RECIP_M   = (longint'(1) << RECIP_SH) / TAG_SCAN_STEP;
    localparam int     RECIP_W   = RECIP_SH - 6;
    localparam int     PROD_W    = TAG_INT_W + RECIP_W;
    localparam int     QUOT_W    = TAG_INT_W - 6;
    localparam int     REM_W     = TAG_INT_W + 1;

    // Datapath widths of the matrix-vector product.
    localparam int MUL_W = 2 * DATA_W;
    localparam int SUM_W = MUL_W + 2;

    // Queue between the front and the back.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Request type codes on the input beat.
    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_POINT = 1'b1;

    typedef enum logic {
        CMD_LOAD  = 1'b0,
        CMD_POINT = 1'b1
    } t_cmd_kind;

    typedef struct packed {
        logic                     req_type;
        logic [POSE_IDX_W-1:0]    pose_index;
        logic [ELEM_W-1:0]        element_index;
        logic signed [DATA_W-1:0] element_value;
        logic signed [DATA_W-1:0] point_x;
        logic signed [DATA_W-1:0] point_y;
        logic signed [DATA_W-1:0] point_z;
        logic [TAG_W-1:0]         point_tag;
    } t_in_item;

    typedef struct packed {
        logic signed [DATA_W-1:0] out_x;
        logic signed [DATA_W-1:0] out_y;
        logic signed [DATA_W-1:0] out_z;
        logic [TAG_W-1:0]         out_tag;
    } t_out_item;

    // Classified work item handed from the front to the back.
    typedef struct packed {
        t_cmd_kind                kind;
        logic [SCAN_W-1:0]        scan;
        logic [ELEM_W-1:0]        elem;
        logic signed [DATA_W-1:0] value;
        logic signed [DATA_W-1:0] x;
        logic signed [DATA_W-1:0] y;
        logic signed [DATA_W-1:0] z;
        logic [TAG_W-1:0]         tag;
    } t_cmd;

endpackage

// ----- design/per_scan_pose_point_transform.sv -----
// Top level of the per-scan pose point transform.
//
// Every input beat either loads one pose element (req_type 0) or transforms one point
// (req_type 1). A load writes element element_index of scan pose_index into the pose
// table and returns no output beat; loads with an element index above 11 are dropped.
// A point beat finds its scan as floor(point_tag / (100 * 2^8)), clamped to the last
// scan, and returns R * p + t rounded to nearest (ties upward) and saturated to 32 bits,
// with the tag passed through untouched. Throughput is one beat per clock in both
// directions while neither side stalls; a point passes through the two front stages
// that derive the scan number, the command queue, the pose table read, the multiply
// stage, the sum stage and the rounding stage feeding the output register. The pose
// table is twelve banks of 256 words, one bank per pose element, so a full pose is
// read at once; it is not cleared by reset, so a pose must be loaded before any point
// refers to it. A load followed directly by a point of the same scan is handled in
// order. A four-entry queue sits between the front end and the transform, so output
// back-pressure reaches the input only once the queue has filled.
module per_scan_pose_point_transform (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  ppt_pkg::t_in_item  i_in_item,
    output logic               o_in_stall,
    output logic               o_out_valid,
    output ppt_pkg::t_out_item o_out_item,
    input  logic               i_out_stall
);

    logic          q_push;
    logic          q_full;
    logic          q_valid;
    logic          q_pop;
    ppt_pkg::t_cmd front_cmd;
    ppt_pkg::t_cmd q_cmd;

    // The front end turns each beat into a command with its scan number resolved.
    ppt_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .i_item  (i_in_item),
        .o_stall (o_in_stall),
        .o_push  (q_push),
        .o_cmd   (front_cmd),
        .i_full  (q_full)
    );

    // The queue lets the front keep taking beats while the back is held up.
    ppt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (front_cmd),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_cmd   (q_cmd),
        .i_pop   (q_pop)
    );

    // The back end owns the pose table and the arithmetic.
    ppt_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_cmd   (q_cmd),
        .o_pop     (q_pop),
        .o_valid   (o_out_valid),
        .o_item    (o_out_item),
        .i_stall   (i_out_stall)
    );

endmodule

// ----- design/ppt_front.sv -----
// Front end: accepts input beats, derives the scan number and drops bad loads.
module ppt_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  ppt_pkg::t_in_item i_item,
    output logic              o_stall,
    output logic              o_push,
    output ppt_pkg::t_cmd     o_cmd,
    input  logic              i_full
);

    logic                           f_en;
    logic                           r_f1_valid;
    ppt_pkg::t_in_item              r_f1_item;
    logic [ppt_pkg::PROD_W-1:0]     r_f1_prod;
    logic [ppt_pkg::PROD_W-1:0]     n_f1_prod;
    logic [ppt_pkg::TAG_INT_W-1:0]  in_tag_int;
    logic [ppt_pkg::TAG_INT_W-1:0]  f1_tag_int;
    logic [ppt_pkg::QUOT_W-1:0]     quot_est;
    logic [ppt_pkg::QUOT_W-1:0]     quot;
    logic [ppt_pkg::REM_W-1:0]      n_rem;
    logic [ppt_pkg::SCAN_W-1:0]     point_scan;
    logic                           is_point;
    logic                           load_ok;
    logic                           r_f2_valid;
    ppt_pkg::t_cmd                  r_f2_cmd;
    ppt_pkg::t_cmd                  n_f2_cmd;

    // The whole front advances together unless its last stage is blocked.
    assign f_en    = !r_f2_valid || !i_full;
    assign o_stall = !f_en;

    assign in_tag_int = i_item.point_tag[ppt_pkg::TAG_W-1:ppt_pkg::TAG_FRAC_BITS];
    assign n_f1_prod  = ppt_pkg::PROD_W'(in_tag_int) * ppt_pkg::PROD_W'(ppt_pkg::RECIP_M);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1_valid <= 1'b0;
        end else if (f_en) begin
            r_f1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (f_en) begin
            r_f1_item <= i_item;
            r_f1_prod <= n_f1_prod;
        end
    end

    // The reciprocal estimate is at most one short; the remainder fixes it.
    assign f1_tag_int = r_f1_item.point_tag[ppt_pkg::TAG_W-1:ppt_pkg::TAG_FRAC_BITS];
    assign quot_est   = r_f1_prod[ppt_pkg::PROD_W-1:ppt_pkg::RECIP_SH];

    always_comb begin
        n_rem = ppt_pkg::REM_W'(f1_tag_int)
              - ppt_pkg::REM_W'(quot_est * ppt_pkg::TAG_SCAN_STEP);
        if (n_rem >= ppt_pkg::REM_W'(ppt_pkg::TAG_SCAN_STEP)) begin
            quot = ppt_pkg::QUOT_W'(quot_est + 1'b1);
        end else begin
            quot = quot_est;
        end
        if (32'(quot) >= ppt_pkg::MAX_SCANS) begin
            point_scan = ppt_pkg::SCAN_W'(ppt_pkg::MAX_SCANS - 1);
        end else begin
            point_scan = ppt_pkg::SCAN_W'(quot);
        end
    end

    assign is_point = (r_f1_item.req_type == ppt_pkg::REQ_POINT);
    assign load_ok  = (32'(r_f1_item.pose_index) < ppt_pkg::MAX_SCANS)
                   && (r_f1_item.element_index < ppt_pkg::ELEM_W'(ppt_pkg::POSE_WORDS));

    always_comb begin
        n_f2_cmd.kind  = is_point ? ppt_pkg::CMD_POINT : ppt_pkg::CMD_LOAD;
        n_f2_cmd.scan  = is_point ? point_scan
                                  : ppt_pkg::SCAN_W'(r_f1_item.pose_index);
        n_f2_cmd.elem  = r_f1_item.element_index;
        n_f2_cmd.value = r_f1_item.element_value;
        n_f2_cmd.x     = r_f1_item.point_x;
        n_f2_cmd.y     = r_f1_item.point_y;
        n_f2_cmd.z     = r_f1_item.point_z;
        n_f2_cmd.tag   = r_f1_item.point_tag;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f2_valid <= 1'b0;
        end else if (f_en) begin
            r_f2_valid <= r_f1_valid && (is_point || load_ok);
        end
    end

    always_ff @(posedge i_clk) begin
        if (f_en) begin
            r_f2_cmd <= n_f2_cmd;
        end
    end

    assign o_push = r_f2_valid && !i_full;
    assign o_cmd  = r_f2_cmd;

    // A wrong reciprocal would leave the remainder beyond one correction step.
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_f1_valid && is_point |-> n_rem < ppt_pkg::REM_W'(2 * ppt_pkg::TAG_SCAN_STEP))
        else $error("scan quotient needs more than one correction");

endmodule

// ----- design/ppt_queue.sv -----
// Short command queue that decouples the front end from the transform back end.
module ppt_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  ppt_pkg::t_cmd i_cmd,
    output logic          o_full,
    output logic          o_valid,
    output ppt_pkg::t_cmd o_cmd,
    input  logic          i_pop
);

    ppt_pkg::t_cmd               r_slot [ppt_pkg::QUEUE_DEPTH];
    logic [ppt_pkg::QPTR_W-1:0]  r_wr_ptr;
    logic [ppt_pkg::QPTR_W-1:0]  r_rd_ptr;
    logic [ppt_pkg::QCNT_W-1:0]  r_count;
    logic [ppt_pkg::QPTR_W-1:0]  n_wr_ptr;
    logic [ppt_pkg::QPTR_W-1:0]  n_rd_ptr;

    assign n_wr_ptr = (r_wr_ptr == ppt_pkg::QPTR_W'(ppt_pkg::QUEUE_DEPTH - 1))
                    ? '0 : ppt_pkg::QPTR_W'(r_wr_ptr + 1'b1);
    assign n_rd_ptr = (r_rd_ptr == ppt_pkg::QPTR_W'(ppt_pkg::QUEUE_DEPTH - 1))
                    ? '0 : ppt_pkg::QPTR_W'(r_rd_ptr + 1'b1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= n_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= n_rd_ptr;
            end
            if (i_push && !i_pop) begin
                r_count <= ppt_pkg::QCNT_W'(r_count + 1'b1);
            end else if (i_pop && !i_push) begin
                r_count <= ppt_pkg::QCNT_W'(r_count - 1'b1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_cmd;
        end
    end

    assign o_full  = (r_count == ppt_pkg::QCNT_W'(ppt_pkg::QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_slot[r_rd_ptr];

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= ppt_pkg::QCNT_W'(ppt_pkg::QUEUE_DEPTH))
        else $error("queue fill count beyond its depth");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> r_count != '0)
        else $error("queue popped while empty");

    a_push_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push && !i_pop |=> r_count == ppt_pkg::QCNT_W'($past(r_count) + 1'b1))
        else $error("queue push not counted");

endmodule

// ----- design/ppt_back.sv -----
// Back end: pose table banks, matrix-vector product, rounding and saturation.
module ppt_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_valid,
    input  ppt_pkg::t_cmd      i_q_cmd,
    output logic               o_pop,
    output logic               o_valid,
    output ppt_pkg::t_out_item o_item,
    input  logic               i_stall
);

    localparam logic signed [ppt_pkg::SUM_W-1:0] ROUND_HALF =
        ppt_pkg::SUM_W'(longint'(1) << (ppt_pkg::ROT_FRAC_BITS - 1));
    localparam logic signed [ppt_pkg::DATA_W-1:0] OUT_MAX =
        {1'b0, {(ppt_pkg::DATA_W - 1){1'b1}}};
    localparam logic signed [ppt_pkg::DATA_W-1:0] OUT_MIN =
        {1'b1, {(ppt_pkg::DATA_W - 1){1'b0}}};

    logic                               b_en;
    logic                               mem_we;
    logic [ppt_pkg::DATA_W-1:0]         r_pose_rd [ppt_pkg::POSE_WORDS];

    logic                               r_s1_valid;
    logic signed [ppt_pkg::DATA_W-1:0]  r_s1_pt [ppt_pkg::POSE_DIM];
    logic [ppt_pkg::TAG_W-1:0]          r_s1_tag;

    logic                               r_s2_valid;
    logic signed [ppt_pkg::MUL_W-1:0]   r_s2_prod [ppt_pkg::POSE_DIM][ppt_pkg::POSE_DIM];
    logic signed [ppt_pkg::MUL_W-1:0]   n_s2_prod [ppt_pkg::POSE_DIM][ppt_pkg::POSE_DIM];
    logic signed [ppt_pkg::DATA_W-1:0]  r_s2_trans [ppt_pkg::POSE_DIM];
    logic [ppt_pkg::TAG_W-1:0]          r_s2_tag;

    logic                               r_s3_valid;
    logic signed [ppt_pkg::SUM_W-1:0]   r_s3_sum [ppt_pkg::POSE_DIM];
    logic signed [ppt_pkg::SUM_W-1:0]   n_s3_sum [ppt_pkg::POSE_DIM];
    logic signed [ppt_pkg::DATA_W-1:0]  r_s3_trans [ppt_pkg::POSE_DIM];
    logic [ppt_pkg::TAG_W-1:0]          r_s3_tag;

    logic signed [ppt_pkg::SUM_W-1:0]   total [ppt_pkg::POSE_DIM];
    logic signed [ppt_pkg::SUM_W-1:0]   rounded [ppt_pkg::POSE_DIM];
    logic signed [ppt_pkg::DATA_W-1:0]  n_coord [ppt_pkg::POSE_DIM];

    logic                               r_out_valid;
    ppt_pkg::t_out_item                 r_out_item;

    // Global advance: the pipeline moves whenever the output register frees up.
    assign b_en   = !r_out_valid || !i_stall;
    assign o_pop  = i_q_valid && b_en;
    assign mem_we = o_pop && (i_q_cmd.kind == ppt_pkg::CMD_LOAD);

    // One bank per pose element, so a whole pose is read at once.
    for (genvar b = 0; b < ppt_pkg::POSE_WORDS; b++) begin : g_bank
        logic [ppt_pkg::DATA_W-1:0] r_mem [ppt_pkg::MAX_SCANS];

        always_ff @(posedge i_clk) begin
            if (mem_we && (i_q_cmd.elem == ppt_pkg::ELEM_W'(b))) begin
                r_mem[i_q_cmd.scan] <= i_q_cmd.value;
            end
            if (b_en) begin
                r_pose_rd[b] <= r_mem[i_q_cmd.scan];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_s3_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (b_en) begin
            r_s1_valid  <= o_pop && (i_q_cmd.kind == ppt_pkg::CMD_POINT);
            r_s2_valid  <= r_s1_valid;
            r_s3_valid  <= r_s2_valid;
            r_out_valid <= r_s3_valid;
        end
    end

    always_comb begin
        for (int r = 0; r < ppt_pkg::POSE_DIM; r++) begin
            for (int k = 0; k < ppt_pkg::POSE_DIM; k++) begin
                n_s2_prod[r][k] =
                    ppt_pkg::MUL_W'($signed(r_pose_rd[r * ppt_pkg::POSE_DIM + k]))
                  * ppt_pkg::MUL_W'(r_s1_pt[k]);
            end
        end
    end

    always_comb begin
        for (int r = 0; r < ppt_pkg::POSE_DIM; r++) begin
            n_s3_sum[r] = ppt_pkg::SUM_W'(r_s2_prod[r][0])
                        + ppt_pkg::SUM_W'(r_s2_prod[r][1])
                        + ppt_pkg::SUM_W'(r_s2_prod[r][2]);
        end
    end

    // Add translation and half an LSB, floor, then clamp to 32 bits.
    always_comb begin
        for (int r = 0; r < ppt_pkg::POSE_DIM; r++) begin
            total[r]   = r_s3_sum[r]
                       + (ppt_pkg::SUM_W'(r_s3_trans[r]) <<< ppt_pkg::ROT_FRAC_BITS)
                       + ROUND_HALF;
            rounded[r] = total[r] >>> ppt_pkg::ROT_FRAC_BITS;
            if (rounded[r] > ppt_pkg::SUM_W'(OUT_MAX)) begin
                n_coord[r] = OUT_MAX;
            end else if (rounded[r] < ppt_pkg::SUM_W'(OUT_MIN)) begin
                n_coord[r] = OUT_MIN;
            end else begin
                n_coord[r] = rounded[r][ppt_pkg::DATA_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_en) begin
            r_s1_pt[0] <= i_q_cmd.x;
            r_s1_pt[1] <= i_q_cmd.y;
            r_s1_pt[2] <= i_q_cmd.z;
            r_s1_tag   <= i_q_cmd.tag;
            r_s2_prod  <= n_s2_prod;
            for (int r = 0; r < ppt_pkg::POSE_DIM; r++) begin
                r_s2_trans[r] <= $signed(r_pose_rd[ppt_pkg::TRANS_BASE + r]);
            end
            r_s2_tag   <= r_s1_tag;
            r_s3_sum   <= n_s3_sum;
            r_s3_trans <= r_s2_trans;
            r_s3_tag   <= r_s2_tag;
            r_out_item.out_x   <= n_coord[0];
            r_out_item.out_y   <= n_coord[1];
            r_out_item.out_z   <= n_coord[2];
            r_out_item.out_tag <= r_s3_tag;
        end
    end

    assign o_valid = r_out_valid;
    assign o_item  = r_out_item;

    a_load_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |=> !r_s1_valid)
        else $error("pose load entered the transform pipeline");

endmodule

// ----- sim/per_scan_pose_point_transform_tb.sv -----
// Self-checking testbench for the per-scan pose point transform, with its own transform predictor.
module per_scan_pose_point_transform_tb;

    // Tag span of one scan: 100 in the integer part of an 8-fraction-bit tag.
    localparam int SCAN_TAG_SPAN  = ppt_pkg::TAG_SCAN_STEP << ppt_pkg::TAG_FRAC_BITS;
    localparam int TAG_MAX        = (1 << ppt_pkg::TAG_W) - 1;
    localparam int ELEM_CODES     = 1 << ppt_pkg::ELEM_W;
    localparam int RANDOM_ITEMS   = 1550;
    localparam int PHASE_ITEMS    = 300;
    localparam int HOLD_AT        = 1250;
    localparam int DRAIN_AT       = 1400;
    localparam int HOLD_CYCLES    = 300;
    localparam int HOLD_POINTS    = 40;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int SETTLE_CYCLES  = 20;
    localparam int MAX_REPORTS    = 40;

    // The exact sum needs 66 bits; 96 leaves plenty of headroom.
    typedef logic signed [95:0] t_wide;
    localparam t_wide ROUND_HALF = t_wide'(1) <<< (ppt_pkg::ROT_FRAC_BITS - 1);
    localparam t_wide COORD_MAX  = 96'sd2147483647;
    localparam t_wide COORD_MIN  = -96'sd2147483648;

    // Directed pose for the last scan. Row 0 is all -2.0, row 1 all just under +2.0,
    // row 2 picks x alone at 1.0; the translation sits at both extremes and at 1.0.
    localparam logic [ppt_pkg::DATA_W-1:0] DIR_POSE [ppt_pkg::POSE_WORDS] = '{
        32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
        32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
        32'h4000_0000, 32'h0000_0000, 32'h0000_0000,
        32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000
    };

    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } t_idle_mode;

    // One row of the directed table. Where typed is set, want is the result read straight
    // off the arithmetic; otherwise the predictor supplies the expectation.
    typedef struct {
        ppt_pkg::t_in_item  item;
        bit                 typed;
        ppt_pkg::t_out_item want;
    } t_stim_row;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    ppt_pkg::t_in_item  i_in_item;
    logic               o_in_stall;
    logic               o_out_valid;
    ppt_pkg::t_out_item o_out_item;
    logic               i_out_stall;

    // Sideband that travels with the input beat, so that a typed expectation is queued
    // at the very edge at which its beat is taken.
    bit                 in_typed;
    ppt_pkg::t_out_item in_want;

    // Predictor state: our own copy of the pose table, and the results still owed.
    logic signed [ppt_pkg::DATA_W-1:0] pose_mem [ppt_pkg::MAX_SCANS * ppt_pkg::POSE_WORDS];
    ppt_pkg::t_out_item                expected_points [$];

    // Scans whose whole pose has been loaded; only these may be named by a point.
    bit scan_ready [ppt_pkg::MAX_SCANS];
    int ready_scans [$];

    int err_count       = 0;
    int results_checked = 0;
    int quiet_cycles    = 0;
    int points_seen     = 0;
    int loads_seen      = 0;
    int dropped_seen    = 0;
    int items_sent      = 0;
    int send_idle_pct   = 0;
    int recv_stall_pct  = 0;
    int hold_requests   = 0;

    per_scan_pose_point_transform u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_item   (i_in_item),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item),
        .i_out_stall (i_out_stall)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // A load writes one word of the table; element codes past the translation are dropped.
    function automatic void store_pose_element(input ppt_pkg::t_in_item it);
        if (int'(it.pose_index) < ppt_pkg::MAX_SCANS
            && int'(it.element_index) < ppt_pkg::POSE_WORDS) begin
            pose_mem[int'(it.pose_index) * ppt_pkg::POSE_WORDS + int'(it.element_index)] =
                it.element_value;
        end
    endfunction

    // R * p + t for the scan named by the tag. The sum is kept exact with
    // ROT_FRAC_BITS + 16 fraction bits, rounded half upward, then clamped to 32 bits.
    function automatic ppt_pkg::t_out_item transform_point(input ppt_pkg::t_in_item it);
        ppt_pkg::t_out_item                res;
        int                                scan;
        int                                base;
        t_wide                             coord [ppt_pkg::POSE_DIM];
        t_wide                             acc;
        logic signed [ppt_pkg::DATA_W-1:0] outc [ppt_pkg::POSE_DIM];
        scan = int'(it.point_tag) / SCAN_TAG_SPAN;
        if (scan >= ppt_pkg::MAX_SCANS) begin
            scan = ppt_pkg::MAX_SCANS - 1;
        end
        base = scan * ppt_pkg::POSE_WORDS;
        coord[0] = t_wide'(it.point_x);
        coord[1] = t_wide'(it.point_y);
        coord[2] = t_wide'(it.point_z);
        for (int row = 0; row < ppt_pkg::POSE_DIM; row++) begin
            acc = t_wide'(pose_mem[base + ppt_pkg::TRANS_BASE + row])
                  <<< ppt_pkg::ROT_FRAC_BITS;
            for (int k = 0; k < ppt_pkg::POSE_DIM; k++) begin
                acc = acc + t_wide'(pose_mem[base + row * ppt_pkg::POSE_DIM + k]) * coord[k];
            end
            acc = (acc + ROUND_HALF) >>> ppt_pkg::ROT_FRAC_BITS;
            if (acc > COORD_MAX) begin
                acc = COORD_MAX;
            end else if (acc < COORD_MIN) begin
                acc = COORD_MIN;
            end
            outc[row] = acc[ppt_pkg::DATA_W-1:0];
        end
        res.out_x   = outc[0];
        res.out_y   = outc[1];
        res.out_z   = outc[2];
        res.out_tag = it.point_tag;
        return res;
    endfunction

    // Prints one line per failure, up to a cap, and counts every one.
    task automatic report_mismatch(input string what);
        err_count++;
        if (err_count <= MAX_REPORTS) begin
            $display("MISMATCH at %0t, result %0d: %s", $realtime, results_checked, what);
        end
    endtask

    // ------------------------------------------------------------------
    // Monitor: output side first, so a result is always matched against what was
    // queued before this edge, then the input side feeds the predictor. Both read
    // values from before the edge, so process order within the time step is moot.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : monitor
        ppt_pkg::t_out_item want;
        bit                 moved;
        moved = 1'b0;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                moved = 1'b1;
                if (expected_points.size() == 0) begin
                    report_mismatch($sformatf("result %h with nothing outstanding", o_out_item));
                end else begin
                    want = expected_points.pop_front();
                    if (o_out_item.out_x !== want.out_x)
                        report_mismatch($sformatf("out_x got %h want %h",
                                                  o_out_item.out_x, want.out_x));
                    if (o_out_item.out_y !== want.out_y)
                        report_mismatch($sformatf("out_y got %h want %h",
                                                  o_out_item.out_y, want.out_y));
                    if (o_out_item.out_z !== want.out_z)
                        report_mismatch($sformatf("out_z got %h want %h",
                                                  o_out_item.out_z, want.out_z));
                    if (o_out_item.out_tag !== want.out_tag)
                        report_mismatch($sformatf("out_tag got %h want %h",
                                                  o_out_item.out_tag, want.out_tag));
                end
                results_checked++;
            end
            if (i_in_valid && !o_in_stall) begin
                moved = 1'b1;
                if (i_in_item.req_type == ppt_pkg::REQ_POINT) begin
                    points_seen++;
                    expected_points.insert(expected_points.size(),
                                           in_typed ? in_want : transform_point(i_in_item));
                end else begin
                    if (int'(i_in_item.element_index) < ppt_pkg::POSE_WORDS) begin
                        loads_seen++;
                    end else begin
                        dropped_seen++;
                    end
                    store_pose_element(i_in_item);
                end
            end
            // Watchdog: a long run of edges on which neither side moves means a hang.
            quiet_cycles = moved ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("Watchdog: no beat moved for %0d cycles, %0d results outstanding",
                         WATCHDOG_LIMIT, expected_points.size());
                $display("per_scan_pose_point_transform_tb: errors");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: random stalls at the current rate, and on request a long hold-off
    // counted here, so that the pipeline and its queue fill and the input stalls.
    // ------------------------------------------------------------------
    initial begin : receiver
        int hold_left;
        int hold_served;
        hold_left   = 0;
        hold_served = 0;
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_requests != hold_served) begin
                hold_served = hold_requests;
                hold_left   = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    task automatic set_idling(input t_idle_mode mode);
        case (mode)
            IDLE_NONE: begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            IDLE_SENDER: begin
                send_idle_pct  = 65;
                recv_stall_pct = 0;
            end
            IDLE_RECEIVER: begin
                send_idle_pct  = 0;
                recv_stall_pct = 65;
            end
            default: begin
                send_idle_pct  = 30;
                recv_stall_pct = 30;
            end
        endcase
    endtask

    function automatic logic signed [ppt_pkg::DATA_W-1:0] extreme_word();
        case ($urandom_range(0, 4))
            0:       return 32'sh8000_0000;
            1:       return 32'sh7FFF_FFFF;
            2:       return 32'sh0000_0000;
            3:       return 32'shFFFF_FFFF;
            default: return 32'sh0000_0001;
        endcase
    endfunction

    // Pose words: mostly plausible rotations within +-1.0 and translations within +-1024
    // metres, with whole and half steps to land on rounding ties, plus extremes
    // and raw noise.
    function automatic logic signed [ppt_pkg::DATA_W-1:0] pose_value(input int elem);
        int half_shift;
        half_shift = (elem < ppt_pkg::TRANS_BASE) ? ppt_pkg::ROT_FRAC_BITS - 1 : 15;
        case ($urandom_range(0, 9))
            0:       return extreme_word();
            1:       return $urandom;
            2, 3:    return (int'($urandom_range(0, 7)) - 4) <<< half_shift;
            default: begin
                if (elem < ppt_pkg::TRANS_BASE)
                    return int'($urandom_range(0, 32'h7FFF_FFFF)) - 32'sh4000_0000;
                return int'($urandom_range(0, 32'h07FF_FFFF)) - 32'sh0400_0000;
            end
        endcase
    endfunction

    // Point coordinates: mostly within +-128 m, sometimes full range or extreme.
    function automatic logic signed [ppt_pkg::DATA_W-1:0] coord_value();
        case ($urandom_range(0, 15))
            0:          return extreme_word();
            1, 2, 3:    return $urandom;
            default:    return int'($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000;
        endcase
    endfunction

    // Fields that a beat's kind leaves unused still carry random bits.
    function automatic ppt_pkg::t_in_item load_beat(
        input int scan, input int elem, input logic signed [ppt_pkg::DATA_W-1:0] value);
        ppt_pkg::t_in_item it;
        it.req_type      = ppt_pkg::REQ_LOAD;
        it.pose_index    = ppt_pkg::POSE_IDX_W'(scan);
        it.element_index = ppt_pkg::ELEM_W'(elem);
        it.element_value = value;
        it.point_x       = $urandom;
        it.point_y       = $urandom;
        it.point_z       = $urandom;
        it.point_tag     = ppt_pkg::TAG_W'($urandom);
        return it;
    endfunction

    function automatic ppt_pkg::t_in_item point_with(
        input logic signed [ppt_pkg::DATA_W-1:0] x,
        input logic signed [ppt_pkg::DATA_W-1:0] y,
        input logic signed [ppt_pkg::DATA_W-1:0] z,
        input int unsigned tag);
        ppt_pkg::t_in_item it;
        it.req_type      = ppt_pkg::REQ_POINT;
        it.pose_index    = ppt_pkg::POSE_IDX_W'($urandom);
        it.element_index = ppt_pkg::ELEM_W'($urandom);
        it.element_value = $urandom;
        it.point_x       = x;
        it.point_y       = y;
        it.point_z       = z;
        it.point_tag     = ppt_pkg::TAG_W'(tag);
        return it;
    endfunction

    // A point of the given scan. For the last scan, half the tags run past the top of
    // the table so that the scan number has to be clamped.
    function automatic ppt_pkg::t_in_item point_beat(input int scan);
        int unsigned tag;
        if (scan == ppt_pkg::MAX_SCANS - 1 && $urandom_range(0, 1) == 1) begin
            tag = $urandom_range(scan * SCAN_TAG_SPAN, TAG_MAX);
        end else begin
            tag = scan * SCAN_TAG_SPAN + $urandom_range(0, SCAN_TAG_SPAN - 1);
        end
        return point_with(coord_value(), coord_value(), coord_value(), tag);
    endfunction

    // Offers one beat and returns at the edge that takes it. Valid is raised only after
    // the random gap, and the payload holds while the block stalls.
    task automatic send_beat(input ppt_pkg::t_in_item item, input bit typed,
                             input ppt_pkg::t_out_item want);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= item;
        in_typed   <= typed;
        in_want    <= want;
        @(posedge i_clk);
        while (o_in_stall) begin
            @(posedge i_clk);
        end
    endtask

    // Beats that the block only drops do not count towards the random total.
    task automatic offer_item(input ppt_pkg::t_in_item item);
        send_beat(item, 1'b0, '0);
        if (item.req_type == ppt_pkg::REQ_POINT
            || int'(item.element_index) < ppt_pkg::POSE_WORDS) begin
            items_sent++;
        end
    endtask

    // Lets every outstanding result drain before the next beat is offered.
    task automatic drain_results();
        i_in_valid <= 1'b0;
        do begin
            @(posedge i_clk);
        end while (expected_points.size() != 0);
    endtask

    // One well-formed sequence: load a whole pose in random order, with the odd dropped
    // load mixed in, then a run of points that mostly use the pose just loaded. Now and
    // then a single element is reloaded directly ahead of a point of the same scan.
    task automatic run_scan_burst(input int scan, input int npts);
        int order [ppt_pkg::POSE_WORDS];
        int pick;
        int tmp;
        int s;
        int e;
        for (int i = 0; i < ppt_pkg::POSE_WORDS; i++) begin
            order[i] = i;
        end
        for (int i = ppt_pkg::POSE_WORDS - 1; i > 0; i--) begin
            pick        = $urandom_range(0, i);
            tmp         = order[i];
            order[i]    = order[pick];
            order[pick] = tmp;
        end
        for (int i = 0; i < ppt_pkg::POSE_WORDS; i++) begin
            if ($urandom_range(0, 9) == 0) begin
                offer_item(load_beat($urandom_range(0, ppt_pkg::MAX_SCANS - 1),
                                     $urandom_range(ppt_pkg::POSE_WORDS, ELEM_CODES - 1),
                                     $urandom));
            end
            offer_item(load_beat(scan, order[i], pose_value(order[i])));
        end
        if (!scan_ready[scan]) begin
            scan_ready[scan] = 1'b1;
            ready_scans.insert(ready_scans.size(), scan);
        end
        for (int n = 0; n < npts; n++) begin
            if ($urandom_range(0, 3) != 0) begin
                s = scan;
            end else begin
                s = ready_scans[$urandom_range(0, ready_scans.size() - 1)];
            end
            if ($urandom_range(0, 11) == 0) begin
                e = $urandom_range(0, ppt_pkg::POSE_WORDS - 1);
                offer_item(load_beat(s, e, pose_value(e)));
            end
            offer_item(point_beat(s));
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin : stimulus
        t_stim_row dir_rows [$];
        bit        hold_done;
        bit        drain_done;
        int        scan;
        int        done;
        hold_done  = 1'b0;
        drain_done = 1'b0;

        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_in_item  <= '0;
        in_typed   <= 1'b0;
        in_want    <= '0;

        // Directed table. The pose of the last scan goes in first, element by element.
        for (int e = 0; e < ppt_pkg::POSE_WORDS; e++) begin
            dir_rows.insert(dir_rows.size(), t_stim_row'{
                load_beat(ppt_pkg::MAX_SCANS - 1, e, DIR_POSE[e]), 1'b0, '0});
        end
        // Loads with element codes past the translation must be dropped. The first would
        // land on element 0 of the last scan if the address were formed as scan * 12 + elem.
        dir_rows.insert(dir_rows.size(), t_stim_row'{
            load_beat(ppt_pkg::MAX_SCANS - 2, ppt_pkg::POSE_WORDS, 32'sh1234_5678),
            1'b0, '0});
        dir_rows.insert(dir_rows.size(), t_stim_row'{
            load_beat(ppt_pkg::MAX_SCANS - 1, ELEM_CODES - 1, 32'sh0), 1'b0, '0});
        // Lowest pose index; scan 0 is loaded in full before any point refers to it.
        dir_rows.insert(dir_rows.size(), t_stim_row'{
            load_beat(0, 0, 32'sh7FFF_FFFF), 1'b0, '0});
        // Most negative point at the largest tag: row 0 overflows upward, row 1 downward,
        // and row 2 gives x plus one exactly. The tag clamps to the last scan.
        dir_rows.insert(dir_rows.size(), t_stim_row'{
            point_with(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, TAG_MAX), 1'b1,
            ppt_pkg::t_out_item'{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8001_0000,
                                 ppt_pkg::TAG_W'(TAG_MAX)}});
        // Origin just past the last scan: the result is the translation itself.
        dir_rows.insert(dir_rows.size(), t_stim_row'{
            point_with(32'sh0, 32'sh0, 32'sh0, ppt_pkg::MAX_SCANS * SCAN_TAG_SPAN), 1'b1,
            ppt_pkg::t_out_item'{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh0001_0000,
                                 ppt_pkg::TAG_W'(ppt_pkg::MAX_SCANS * SCAN_TAG_SPAN)}});
        // The remaining rows are left to the predictor.
        dir_rows.insert(dir_rows.size(), t_stim_row'{
            point_with(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                       ppt_pkg::MAX_SCANS * SCAN_TAG_SPAN - 1), 1'b0, '0});
        dir_rows.insert(dir_rows.size(), t_stim_row'{
            point_with(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh1234_5678,
                       (ppt_pkg::MAX_SCANS - 1) * SCAN_TAG_SPAN), 1'b0, '0});
        dir_rows.insert(dir_rows.size(), t_stim_row'{
            point_with(32'sh0001_8000, 32'sh0, 32'shFFFF_FFFF,
                       ppt_pkg::MAX_SCANS * SCAN_TAG_SPAN + 12345), 1'b0, '0});

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        set_idling(IDLE_NONE);
        foreach (dir_rows[i]) begin
            send_beat(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].want);
        end
        scan_ready[ppt_pkg::MAX_SCANS - 1] = 1'b1;
        ready_scans.insert(ready_scans.size(), ppt_pkg::MAX_SCANS - 1);
        items_sent = 0;

        // Random part, in idling phases: none, sender gaps, receiver stalls, both; then a
        // mix that changes with every sequence. Partway through, the receiver holds off
        // for a long stretch while points keep coming, and later the sender waits for
        // every result before carrying on.
        while (items_sent < RANDOM_ITEMS) begin
            done = items_sent;
            if (done < 4 * PHASE_ITEMS) begin
                set_idling(t_idle_mode'(done / PHASE_ITEMS));
            end else begin
                set_idling(t_idle_mode'($urandom_range(0, 3)));
            end
            case ($urandom_range(0, 7))
                0:       scan = ppt_pkg::MAX_SCANS - 1;
                1:       scan = 0;
                default: scan = $urandom_range(0, ppt_pkg::MAX_SCANS - 1);
            endcase
            if (!hold_done && done >= HOLD_AT) begin
                hold_done     = 1'b1;
                send_idle_pct = 0;
                hold_requests++;
                run_scan_burst(scan, HOLD_POINTS);
            end else begin
                if (!drain_done && done >= DRAIN_AT) begin
                    drain_done = 1'b1;
                    drain_results();
                end
                run_scan_burst(scan, $urandom_range(1, 16));
            end
        end

        // Wind down: wait for the last result, then a few more edges in case of strays.
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (expected_points.size() != 0) begin
            report_mismatch($sformatf("%0d results never arrived", expected_points.size()));
        end

        $display("Covered %0d points, %0d pose loads and %0d dropped loads across %0d scans,",
                 points_seen, loads_seen, dropped_seen, ready_scans.size());
        $display("with %0d results checked under gaps, stalls and a long output hold-off.",
                 results_checked);
        if (err_count == 0) begin
            $display("per_scan_pose_point_transform_tb: clean");
        end else begin
            $display("per_scan_pose_point_transform_tb: errors");
        end
        $finish;
    end

endmodule
